[rtl/assert_macros.svh]
// Assertion macros for the block's RTL, included by the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/whs_pkg.sv]
// ----------------------------------------------------------------------------
// whs_pkg
// Types, codes and constants of the weighted histogram scatter-add engine.
// ----------------------------------------------------------------------------
package whs_pkg;

	localparam int NUM_BINS_DEF = 4096;
	localparam int CNT_W        = 13;
	localparam int ADDR_W       = 32;
	localparam int SAMPLE_W     = 32;
	localparam int SUM_W        = 48;
	localparam logic [CNT_W-1:0] BIN_COUNT_RESET = 13'd4096;

	localparam logic OP_ACC  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [1:0] ST_ACC   = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	typedef struct packed {
		logic                       operation;
		logic signed [ADDR_W-1:0]   bin_address;
		logic signed [SAMPLE_W-1:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [SUM_W-1:0] bin_sum;
	} out_item_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_WRITE
	} state_t;

	typedef struct packed {
		logic clr_en;
		logic capture;
		logic rd_en;
		logic wr_commit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_busy;
	} sts_t;

endpackage

[rtl/whs_ctrl.sv]
// ----------------------------------------------------------------------------
// whs_ctrl
// Sequencer: clearing pass after reset, then capture, bin read and write-back.
// ----------------------------------------------------------------------------
module whs_ctrl import whs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_WRITE;
			end
			S_WRITE: begin
				if (!sts.out_busy) state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
			end
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
			end
			S_WRITE: begin
				cmd.wr_commit = !sts.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[rtl/whs_dp.sv]
// ----------------------------------------------------------------------------
// whs_dp
// Bin store, range check, saturating accumulator and output register.
// ----------------------------------------------------------------------------
module whs_dp import whs_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  cmd_t             cmd,
	output sts_t             sts
);

	localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int EXT_W = SUM_W - SAMPLE_W + 1;

	logic signed [SUM_W-1:0]    mem [NUM_BINS];
	logic [CNT_W-1:0]           bin_count_q;
	logic [IDX_W-1:0]           clr_q;
	logic                       op_q;
	logic                       inrange_q;
	logic [IDX_W-1:0]           addr_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SUM_W-1:0]    rdata_q;
	logic                       out_valid_q;
	out_item_t                  out_q;

	logic [ADDR_W-1:0]       limit;
	logic                    inrange;
	logic signed [SUM_W:0]   sum_wide;
	logic                    sat;
	logic signed [SUM_W-1:0] sum_sat;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	logic signed [SUM_W-1:0] wr_data;
	out_item_t               result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= BIN_COUNT_RESET;
		end else if (cfg_we) begin
			bin_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_q == IDX_W'(NUM_BINS - 1));

	always_comb begin
		if (ADDR_W'(bin_count_q) > ADDR_W'(NUM_BINS)) begin
			limit = ADDR_W'(NUM_BINS);
		end else begin
			limit = ADDR_W'(bin_count_q);
		end
	end

	assign inrange = !in_data.bin_address[ADDR_W-1] &&
		(ADDR_W'(unsigned'(in_data.bin_address)) < limit);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= in_data.operation;
			inrange_q <= inrange;
			addr_q    <= in_data.bin_address[IDX_W-1:0];
			sample_q  <= in_data.sample_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[addr_q];
		end
	end

	assign sum_wide = {rdata_q[SUM_W-1], rdata_q} +
		{{EXT_W{sample_q[SAMPLE_W-1]}}, sample_q};
	assign sat = sum_wide[SUM_W] != sum_wide[SUM_W-1];

	always_comb begin
		if (!sat) begin
			sum_sat = sum_wide[SUM_W-1:0];
		end else if (sum_wide[SUM_W]) begin
			sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
		end
	end

	always_comb begin
		if (!inrange_q) begin
			result.status  = ST_RANGE;
			result.bin_sum = '0;
		end else if (op_q == OP_READ) begin
			result.status  = ST_READ;
			result.bin_sum = rdata_q;
		end else begin
			result.status  = sat ? ST_SAT : ST_ACC;
			result.bin_sum = sum_sat;
		end
	end

	always_comb begin
		if (cmd.clr_en) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = cmd.wr_commit && inrange_q;
			wr_addr = addr_q;
			wr_data = (op_q == OP_READ) ? '0 : sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wr_commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_commit) begin
			out_q <= result;
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

[rtl/weighted_histogram_scatter_add_core.sv]
// ----------------------------------------------------------------------------
// weighted_histogram_scatter_add_core: a new transfer is taken only after the last
// one has passed capture, bin read and write-back, which registers the result and
// waits while the output holds one not yet taken. After reset a clearing pass zeroes
// every bin before the first transfer; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module weighted_histogram_scatter_add_core import whs_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	cmd_t cmd;
	sts_t sts;

	whs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	whs_dp #(
		.NUM_BINS (NUM_BINS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_IMPL(a_commit_not_over_stall, clk, arst_n, cmd.wr_commit, !(out_valid && !out_ready))
	`ASSERT_IMPL(a_result_from_commit, clk, arst_n, $rose(out_valid), $past(cmd.wr_commit))

endmodule

[dv/tb_weighted_histogram_scatter_add_core.sv]
// ----------------------------------------------------------------------------
// tb_weighted_histogram_scatter_add_core
// Self-checking testbench of the weighted histogram scatter-add engine. A
// scoreboard keeps its own copy of the bin sums and the bin count, works out
// the status and sum of every accepted input transfer, and checks each output
// transfer against the oldest outstanding one. The run drives directed corner
// cases, a complete accumulate and read-back dataset and random traffic under
// several bin counts, with random idling on both sides and one long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_weighted_histogram_scatter_add_core import whs_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BINS    = NUM_BINS_DEF;
	localparam int HOLD_CYCLES = 300;

	class bin_sum_tracker;
		logic signed [SUM_W-1:0] sums [NUM_BINS];
		logic [CNT_W-1:0]        bin_count;
		out_item_t               pending [$];
		int                      errors;
		int                      n_acc;
		int                      n_sat;
		int                      n_read;
		int                      n_range;

		function new();
			foreach (sums[i])
				sums[i] = '0;
			bin_count = BIN_COUNT_RESET;
			errors    = 0;
			n_acc     = 0;
			n_sat     = 0;
			n_read    = 0;
			n_range   = 0;
		endfunction

		function void set_count(logic [CNT_W-1:0] value);
			bin_count = value;
		endfunction

		function int unsigned effective_bins();
			return (bin_count > NUM_BINS) ? NUM_BINS : bin_count;
		endfunction

		function void note_item(in_item_t item);
			logic [ADDR_W-1:0]     a;
			logic signed [SUM_W:0] wide;
			out_item_t             exp;
			a = item.bin_address;
			if (a[ADDR_W-1] || a >= effective_bins()) begin
				exp.status  = ST_RANGE;
				exp.bin_sum = '0;
				n_range++;
			end else if (item.operation == OP_READ) begin
				exp.status  = ST_READ;
				exp.bin_sum = sums[a];
				sums[a]     = '0;
				n_read++;
			end else begin
				wide = (SUM_W+1)'(sums[a]) + (SUM_W+1)'(item.sample_value);
				if (wide[SUM_W] != wide[SUM_W-1]) begin
					exp.status  = ST_SAT;
					exp.bin_sum = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
					                          : {1'b0, {(SUM_W-1){1'b1}}};
					n_sat++;
				end else begin
					exp.status  = ST_ACC;
					exp.bin_sum = wide[SUM_W-1:0];
				end
				sums[a] = exp.bin_sum;
				n_acc++;
			end
			pending.push_back(exp);
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result: status %0d, bin_sum %0d", got.status, got.bin_sum);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status) begin
				$error("status mismatch: expected %0d, actual %0d", exp.status, got.status);
				errors++;
			end
			if (got.bin_sum !== exp.bin_sum) begin
				$error("bin_sum mismatch: expected %0d, actual %0d", exp.bin_sum, got.bin_sum);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_ready;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_ready;
	out_item_t        out_data;

	bin_sum_tracker sb;
	bit             tx_bursts;
	bit             rx_bursts;
	bit             hold_out;
	int             settings_used;

	weighted_histogram_scatter_add_core #(
		.NUM_BINS(NUM_BINS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
			end else if (rx_bursts && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		#15_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic in_item_t make_item(logic op, logic [31:0] addr, logic [31:0] sample);
		in_item_t it;
		it.operation    = op;
		it.bin_address  = addr;
		it.sample_value = sample;
		return it;
	endfunction

	function automatic in_item_t random_item(int unsigned span);
		in_item_t    it;
		int unsigned pick;
		int unsigned near;
		pick = $urandom_range(0, 99);
		near = (span > 24) ? 24 : span;
		it.operation = ($urandom_range(0, 3) == 0) ? OP_READ : OP_ACC;
		if (span != 0 && pick < 60)
			it.bin_address = $urandom_range(0, near - 1);
		else if (span != 0 && pick < 72)
			it.bin_address = $urandom_range(0, span - 1);
		else if (pick < 84)
			it.bin_address = span + $urandom_range(0, 3) - 2;
		else if (pick < 92)
			it.bin_address = $urandom | 32'h8000_0000;
		else
			it.bin_address = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			it.sample_value = $urandom;
		else if (pick < 80)
			it.sample_value = $urandom_range(0, 255) - 128;
		else if (pick < 90)
			it.sample_value = 32'h7FFF_FFFF;
		else
			it.sample_value = 32'h8000_0000;
		return it;
	endfunction

	task automatic send_item(input in_item_t item);
		in_valid <= 1'b1;
		in_data  <= item;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic tx_pause();
		if (tx_bursts && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_bin_count(input logic [CNT_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_count(value);
		settings_used++;
	endtask

	task automatic send_random(input int count);
		repeat (count) begin
			send_item(random_item(sb.effective_bins()));
			tx_pause();
		end
	endtask

	initial begin
		logic [CNT_W-1:0] plan [7];
		int               drain;
		int               p;
		sb            = new();
		settings_used = 0;
		tx_bursts     = 1'b1;
		rx_bursts     = 1'b1;
		hold_out      = 1'b0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed corner cases.
		write_bin_count(13'd16);
		send_item(make_item(OP_ACC, 32'd0, 32'h7FFF_FFFF));
		send_item(make_item(OP_ACC, 32'd0, 32'h8000_0000));
		send_item(make_item(OP_ACC, 32'd15, 32'h0001_0000));
		send_item(make_item(OP_ACC, 32'd16, 32'd1));
		send_item(make_item(OP_ACC, 32'hFFFF_FFFF, 32'd5));
		send_item(make_item(OP_ACC, 32'h8000_0000, 32'd5));
		send_item(make_item(OP_ACC, 32'h7FFF_FFFF, 32'd5));
		send_item(make_item(OP_READ, 32'd16, 32'hFFFF_FFFF));
		send_item(make_item(OP_READ, 32'h8000_0000, 32'd0));
		send_item(make_item(OP_ACC, 32'd3, 32'h0000_1234));
		send_item(make_item(OP_ACC, 32'd3, 32'hFFFF_0000));
		send_item(make_item(OP_READ, 32'd3, 32'd0));
		send_item(make_item(OP_READ, 32'd3, 32'd0));
		send_item(make_item(OP_ACC, 32'd10, 32'h0003_0000));
		write_bin_count(13'd4);
		send_item(make_item(OP_READ, 32'd10, 32'd0));
		send_item(make_item(OP_ACC, 32'd3, 32'd1));
		write_bin_count(13'd0);
		send_item(make_item(OP_ACC, 32'd0, 32'd7));
		send_item(make_item(OP_READ, 32'd0, 32'd0));
		write_bin_count(13'd8191);
		send_item(make_item(OP_ACC, 32'd4095, 32'h7FFF_FFFF));
		send_item(make_item(OP_ACC, 32'd4096, 32'd1));
		send_item(make_item(OP_READ, 32'd4095, 32'd0));
		write_bin_count(13'd16);
		send_item(make_item(OP_READ, 32'd10, 32'd0));
		send_item(make_item(OP_READ, 32'd0, 32'd0));
		write_bin_count(13'd1);
		send_item(make_item(OP_ACC, 32'd0, 32'h0000_8000));
		send_item(make_item(OP_READ, 32'd1, 32'd0));

		// Random traffic under a range of bin counts.
		tx_bursts = 1'b1;
		rx_bursts = 1'b1;
		plan[0] = 13'd8191;
		plan[1] = CNT_W'($urandom_range(1, 64));
		plan[2] = 13'd4097;
		plan[3] = 13'd2;
		plan[4] = CNT_W'($urandom_range(1, 4096));
		plan[5] = 13'd0;
		plan[6] = CNT_W'($urandom_range(1, 64));
		for (p = 0; p < 7; p++) begin
			write_bin_count(plan[p]);
			send_random((plan[p] == 0) ? 40 : 75);
		end

		// Long output hold-off while the input keeps offering transfers.
		write_bin_count(13'd24);
		hold_out = 1'b1;
		repeat (40)
			send_item(random_item(sb.effective_bins()));
		send_random(60);

		// One complete dataset: accumulate, then read every bin back.
		write_bin_count(13'd32);
		repeat (150) begin
			send_item(make_item(OP_ACC, $urandom_range(0, 31), $urandom));
			tx_pause();
		end
		for (p = 0; p < 32; p++) begin
			send_item(make_item(OP_READ, p, $urandom));
			tx_pause();
		end

		tx_bursts = 1'b0;
		rx_bursts = 1'b0;
		write_bin_count(CNT_W'($urandom_range(1, 4096)));
		send_random(60);

		in_valid <= 1'b0;
		@(posedge clk);
		for (drain = 0; drain < 100000 && sb.pending.size() != 0; drain++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d expected results never arrived", sb.pending.size());
			sb.errors++;
		end

		$display("Covered %0d accumulates (%0d saturating), %0d reads and %0d out-of-range items",
		         sb.n_acc, sb.n_sat, sb.n_read, sb.n_range);
		$display("across %0d bin-count settings, with random idling and a long output hold-off.",
		         settings_used);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
